// ===== sv/cse_pkg.sv =====
// package for the capacitive slider engine: op codes, register indexes, fsm states
// no dependencies
package cse_pkg;
    localparam int MaxElectrodes = 16;
    localparam int SliderSpan    = 40;
    localparam int NoTouchCode   = 0;

    typedef enum logic [1:0] {
        OP_CAL   = 2'd0,
        OP_MEAS  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [2:0] REG_THRESH = 3'd0;
    localparam logic [2:0] REG_COUNT  = 3'd1;
    localparam logic [2:0] REG_LOW    = 3'd2;
    localparam logic [2:0] REG_MID    = 3'd3;
    localparam logic [2:0] REG_HIGH   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV0,
        ST_DIV1,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic exec;
        logic div0_start;
        logic div1_start;
        logic finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic need_calc;
        logic div_done;
    } t_status;
endpackage

// ===== sv/cse_if.sv =====
// valid/ready channel interfaces for items, results and configuration writes
// depends on nothing
interface cse_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] scan_count;
    logic [3:0]  electrode_index;
    logic [7:0]  level_in;
    modport source (output valid, op, scan_count, electrode_index, level_in, input ready);
    modport sink   (input valid, op, scan_count, electrode_index, level_in, output ready);
endinterface

interface cse_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] next_electrode;
    logic       touched;
    logic [7:0] slider_percent;
    logic [7:0] slider_distance;
    logic [7:0] level_out;
    logic [3:0] region_four;
    logic [2:0] region_three;
    modport source (output valid, next_electrode, touched, slider_percent, slider_distance,
                    level_out, region_four, region_three, input ready);
    modport sink   (input valid, next_electrode, touched, slider_percent, slider_distance,
                    level_out, region_four, region_three, output ready);
endinterface

interface cse_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/cse_ctrl.sv =====
// controller fsm: sequences execute, two serial divisions and the result transfer
// depends on cse_pkg
module cse_ctrl import cse_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC:   n_state = (i_status.is_query && i_status.need_calc) ? ST_DIV0 : ST_FINISH;
            ST_DIV0:   if (i_status.div_done) n_state = ST_DIV1;
            ST_DIV1:   if (i_status.div_done) n_state = ST_FINISH;
            ST_FINISH: n_state = ST_OUT;
            ST_OUT:    if (i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_EXEC: begin
                o_cmd.exec       = 1'b1;
                o_cmd.div0_start = i_status.is_query && i_status.need_calc;
            end
            ST_DIV0:   o_cmd.div1_start = i_status.div_done;
            ST_DIV1:   ;
            ST_FINISH: o_cmd.finish = 1'b1;
            ST_OUT:    o_out_valid = 1'b1;
            default:   ;
        endcase
        o_cmd.out_load = (r_state == ST_FINISH);
    end
endmodule

// ===== sv/cse_div.sv =====
// restoring serial divider, one quotient bit per cycle
// depends on nothing
module cse_div #(
    parameter int W = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quot
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_rem, r_quot, r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    w_trial;

    assign w_trial = {r_rem, r_quot[W-1]} - {1'b0, r_den};

    // done pulses the cycle after the last step, when the quotient is complete
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_trial[W]) begin
                r_rem  <= w_trial[W-1:0];
                r_quot <= {r_quot[W-2:0], 1'b1};
            end else begin
                r_rem  <= {r_rem[W-2:0], r_quot[W-1]};
                r_quot <= {r_quot[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== sv/cse_dp.sv =====
// datapath: stores, pointer, held position, serial divisions and result fields
// depends on cse_pkg, cse_div
module cse_dp import cse_pkg::*; #(
    parameter int MAX_ELECTRODES = MaxElectrodes,
    parameter int SLIDER_SPAN    = SliderSpan,
    parameter int NO_TOUCH_CODE  = NoTouchCode
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_take,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_scan_count,
    input  logic [3:0]  i_electrode_index,
    input  logic [7:0]  i_level_in,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [3:0]  o_next_electrode,
    output logic        o_touched,
    output logic [7:0]  o_slider_percent,
    output logic [7:0]  o_slider_distance,
    output logic [7:0]  o_level_out,
    output logic [3:0]  o_region_four,
    output logic [2:0]  o_region_three
);
    localparam int DW = 24;
    localparam logic [7:0] NoTouch = 8'(NO_TOUCH_CODE);

    logic [15:0] r_thresh;
    logic [4:0]  r_count;
    logic [6:0]  r_low, r_mid, r_high;
    logic [15:0] r_base [MAX_ELECTRODES];
    logic [15:0] r_delta [MAX_ELECTRODES];
    logic [3:0]  r_ptr;
    logic        r_new;
    logic [7:0]  r_pct, r_dist, r_prev;
    logic        r_touch;
    logic [1:0]  r_op;
    logic [15:0] r_cnt_in;
    logic [3:0]  r_eidx;
    logic [7:0]  r_lvl;
    logic [6:0]  r_p0;
    logic        r_calc;

    logic [16:0]   w_sum;
    logic          w_hit;
    logic [DW-1:0] w_num, w_quot;
    logic          w_done;
    logic [4:0]    w_n;
    logic [3:0]    w_pidx;
    logic [15:0]   w_bsel;
    logic [6:0]    w_p1;
    logic [14:0]   w_s0m, w_s1m;
    logic [7:0]    w_s0, w_s1;
    logic [3:0]    w_r4;
    logic [2:0]    w_r3;

    assign w_sum  = {1'b0, r_delta[0]} + {1'b0, r_delta[1]};
    assign w_hit  = (r_delta[0] > r_thresh) || (r_delta[1] > r_thresh);
    assign w_num  = i_cmd.div0_start ? DW'(r_delta[0]) * DW'(100) : DW'(r_delta[1]) * DW'(100);
    assign w_pidx = r_ptr;
    assign w_bsel = r_base[w_pidx];
    assign w_n    = (r_count > 5'(MAX_ELECTRODES)) ? 5'(MAX_ELECTRODES) : r_count;
    assign w_p1   = w_quot[6:0];
    // span scaling: s = p*span/100, p <= 100 so reciprocal 41944/2^22 is exact
    assign w_s0m  = 15'(r_p0) * 15'(SLIDER_SPAN);
    assign w_s1m  = 15'(w_p1) * 15'(SLIDER_SPAN);
    assign w_s0   = 8'((w_s0m * 32'd41944) >> 22);
    assign w_s1   = 8'((w_s1m * 32'd41944) >> 22);

    cse_div #(.W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div0_start || i_cmd.div1_start),
        .i_num   (w_num),
        .i_den   (DW'(w_sum)),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    assign o_status.is_query  = (r_op == OP_QUERY);
    assign o_status.need_calc = r_new && w_hit;
    assign o_status.div_done  = w_done;

    always_comb begin
        w_r4 = '0;
        w_r3 = '0;
        if (r_touch) begin
            priority if (r_pct >= {1'b0, r_high}) w_r4 = 4'b1000;
            else if (r_pct >= {1'b0, r_mid})      w_r4 = 4'b0100;
            else if (r_pct >= {1'b0, r_low})      w_r4 = 4'b0010;
            else if (r_pct >= 8'd1)               w_r4 = 4'b0001;
            else                                  w_r4 = 4'b0000;
            priority if (r_pct >= {1'b0, r_mid})  w_r3 = 3'b100;
            else if (r_pct >= {1'b0, r_low})      w_r3 = 3'b010;
            else if (r_pct >= 8'd1)               w_r3 = 3'b001;
            else                                  w_r3 = 3'b000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_take) begin
            r_op     <= i_op;
            r_cnt_in <= i_scan_count;
            r_eidx   <= i_electrode_index;
            r_lvl    <= i_level_in;
        end
        if (w_done && !r_calc) r_p0 <= w_quot[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 16'd300;
            r_count  <= 5'd2;
            r_low    <= 7'd25;
            r_mid    <= 7'd50;
            r_high   <= 7'd75;
            for (int k = 0; k < MAX_ELECTRODES; k++) begin
                r_base[k]  <= '0;
                r_delta[k] <= '0;
            end
            r_ptr   <= '0;
            r_new   <= 1'b0;
            r_pct   <= NoTouch;
            r_dist  <= NoTouch;
            r_prev  <= '0;
            r_touch <= 1'b0;
            r_calc  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_THRESH: r_thresh <= i_cfg_data;
                    REG_COUNT:  r_count  <= i_cfg_data[4:0];
                    REG_LOW:    r_low    <= i_cfg_data[6:0];
                    REG_MID:    r_mid    <= i_cfg_data[6:0];
                    REG_HIGH:   r_high   <= i_cfg_data[6:0];
                    default:    ;
                endcase
            end
            if (i_cmd.div0_start) r_calc <= 1'b0;
            if (w_done) r_calc <= 1'b1;
            if (i_cmd.exec) begin
                unique case (t_op'(r_op))
                    OP_CAL: begin
                        r_base[r_eidx] <= r_cnt_in;
                        r_new <= 1'b1;
                    end
                    OP_MEAS: begin
                        r_delta[w_pidx] <= (r_cnt_in > w_bsel) ? r_cnt_in - w_bsel : '0;
                        if (w_n > 5'd1)
                            r_ptr <= ((w_n - 5'd1) > {1'b0, r_ptr}) ? r_ptr + 4'd1 : '0;
                        r_new <= 1'b1;
                    end
                    OP_QUERY: begin
                        if (r_new) begin
                            r_new <= 1'b0;
                            if (!w_hit) begin
                                r_pct   <= NoTouch;
                                r_dist  <= NoTouch;
                                r_touch <= 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            // second quotient available at its done cycle
            if (w_done && r_calc) begin
                r_pct   <= 8'((9'd100 - 9'(r_p0) + 9'(w_p1)) >> 1);
                r_dist  <= 8'((9'(SLIDER_SPAN) - 9'(w_s0) + 9'(w_s1)) >> 1);
                r_touch <= 1'b1;
            end
            if (i_cmd.finish && r_op == OP_QUERY) r_prev <= r_pct;
        end
    end

    // result register, loaded at finish
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_next_electrode <= r_ptr;
            if (r_op == OP_QUERY) begin
                o_touched         <= r_touch;
                o_slider_percent  <= r_pct;
                o_slider_distance <= r_dist;
                if (r_pct > r_prev)      o_level_out <= (r_lvl != 8'hFF) ? r_lvl + 8'd1 : r_lvl;
                else if (r_pct < r_prev) o_level_out <= (r_lvl != 8'h00) ? r_lvl - 8'd1 : r_lvl;
                else                     o_level_out <= r_lvl;
                o_region_four  <= w_r4;
                o_region_three <= w_r3;
            end else begin
                o_touched         <= 1'b0;
                o_slider_percent  <= '0;
                o_slider_distance <= '0;
                o_level_out       <= '0;
                o_region_four     <= '0;
                o_region_three    <= '0;
            end
        end
    end
endmodule

// ===== sv/capacitive_slider_engine_top.sv =====
// capacitive slider engine top: controller, datapath and channel ports
// sequence: items other than a query that recomputes the position pass through execute,
// finish and output; a query that recomputes runs two 24-step serial divisions before finish
// one item in flight; the next input can be taken in the cycle after the result transfer
// reset: synchronous active low, stores and pointer clear, registers take defaults
module capacitive_slider_engine_top import cse_pkg::*; #(
    parameter int MAX_ELECTRODES = MaxElectrodes,
    parameter int SLIDER_SPAN    = SliderSpan,
    parameter int NO_TOUCH_CODE  = NoTouchCode
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cse_in_if.sink    in_ch,
    cse_out_if.source out_ch,
    cse_cfg_if.sink   cfg_ch
);
    t_cmd    w_cmd;
    t_status w_status;

    assign cfg_ch.ready = 1'b1;

    cse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    cse_dp #(
        .MAX_ELECTRODES (MAX_ELECTRODES),
        .SLIDER_SPAN    (SLIDER_SPAN),
        .NO_TOUCH_CODE  (NO_TOUCH_CODE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_take         (in_ch.valid && in_ch.ready),
        .i_op              (in_ch.op),
        .i_scan_count      (in_ch.scan_count),
        .i_electrode_index (in_ch.electrode_index),
        .i_level_in        (in_ch.level_in),
        .i_cfg_we          (cfg_ch.valid),
        .i_cfg_index       (cfg_ch.index),
        .i_cfg_data        (cfg_ch.data),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_next_electrode  (out_ch.next_electrode),
        .o_touched         (out_ch.touched),
        .o_slider_percent  (out_ch.slider_percent),
        .o_slider_distance (out_ch.slider_distance),
        .o_level_out       (out_ch.level_out),
        .o_region_four     (out_ch.region_four),
        .o_region_three    (out_ch.region_three)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("input taken while result pending");
    a_take_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |=> w_cmd.exec) else $error("accepted item not executed");
    a_region_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> ($onehot0(out_ch.region_four) && $onehot0(out_ch.region_three)))
        else $error("region not one-hot");
endmodule
